/* rtl/core/kprd_pkg.sv */
// Shared types and constants for the keypad release detector.
// No dependencies; used by every module in rtl/core.
package kprd_pkg;

  localparam int unsigned NUM_KEYS_DEF   = 16;
  localparam int unsigned IN_KEYS        = 16;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [3:0]  FN_KEY_RESET   = 4'd0;

  // event queue between walker and output stage
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // register index taken from paddr[2]
  localparam logic REG_FN_KEY   = 1'b0;
  localparam logic REG_DEBOUNCE = 1'b1;

  typedef struct packed {
    logic [3:0] key_index;
    logic       fn_layer;
    logic       last;
  } evt_t;

endpackage

/* rtl/core/kprd_front.sv */
// Front end: accepts a key sample, walks keys one per cycle unless the queue is full,
// keeps levels and event times, pushes accepted release events. Depends on kprd_pkg.
module kprd_front import kprd_pkg::*; #(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] levels_i,
  input  logic [31:0] now_i,
  input  logic [3:0]  fn_key_i,
  input  logic [15:0] debounce_i,
  output logic        push_o,
  output evt_t        evt_o,
  input  logic        full_i
);

  localparam int unsigned KW = $clog2(NUM_KEYS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  state_e              state_q;
  logic [KW-1:0]       key_q;
  logic [NUM_KEYS-1:0] sample_q;
  logic [NUM_KEYS-1:0] stored_q;
  logic [31:0]         now_q;
  logic [31:0]         time_q [NUM_KEYS];
  logic                pend_valid_q;
  logic [3:0]          pend_key_q;
  logic                pend_fn_q;

  logic [NUM_KEYS-1:0] levels_ext;
  logic                cur_new;
  logic                changed;
  logic [31:0]         elapsed;
  logic                hit;
  logic                fn_ok;
  logic                fn_layer;
  logic                need_push;
  logic                stall;
  logic                last_key;

  // keys without an input bit read high
  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_ext
    if (i < IN_KEYS) begin : g_in
      assign levels_ext[i] = levels_i[i];
    end else begin : g_hi
      assign levels_ext[i] = 1'b1;
    end
  end

  always_comb begin
    cur_new  = sample_q[key_q];
    changed  = cur_new ^ stored_q[key_q];
    elapsed  = now_q - time_q[key_q];
    hit      = changed && !cur_new && (elapsed > {16'd0, debounce_i});
    fn_ok    = (32'(fn_key_i) < NUM_KEYS);
    fn_layer = fn_ok && stored_q[KW'(fn_key_i)] && (32'(fn_key_i) != 32'(key_q));
    last_key = (key_q == KW'(NUM_KEYS - 1));
    case (state_q)
      ST_WALK:  need_push = hit && pend_valid_q;
      ST_FLUSH: need_push = pend_valid_q;
      default:  need_push = 1'b0;
    endcase
    stall  = need_push && full_i;
    push_o = need_push && !full_i;
    evt_o.key_index = pend_key_q;
    evt_o.fn_layer  = pend_fn_q;
    evt_o.last      = (state_q == ST_FLUSH);
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      key_q        <= '0;
      stored_q     <= '1;
      pend_valid_q <= 1'b0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        time_q[i] <= '0;
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            sample_q <= levels_ext;
            now_q    <= now_i;
            key_q    <= '0;
            state_q  <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!stall) begin
            if (changed) begin
              stored_q[key_q] <= cur_new;
            end
            if (hit) begin
              // hold this event until the next one or the end of the walk
              time_q[key_q] <= now_q;
              pend_valid_q  <= 1'b1;
              pend_key_q    <= 4'(key_q);
              pend_fn_q     <= fn_layer;
            end
            if (last_key) begin
              state_q <= ST_FLUSH;
            end else begin
              key_q <= key_q + 1'b1;
            end
          end
        end
        ST_FLUSH: begin
          if (!stall) begin
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i) else $error("event pushed into full queue");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q) else $error("event left behind at idle");

endmodule

/* rtl/core/kprd_queue.sv */
// Short event queue between the key walker and the output stage.
// Depends on kprd_pkg for the event type and depth.
module kprd_queue import kprd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  evt_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output evt_t pop_data_o
);

  evt_t             mem_q [QDEPTH];
  logic [QPW-1:0]   wr_q;
  logic [QPW-1:0]   rd_q;
  logic [QCW-1:0]   count_q;

  assign full_o     = (count_q == QCW'(QDEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == QPW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == QPW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCW'(QDEPTH)) else $error("queue count out of range");

endmodule

/* rtl/core/kprd_back.sv */
// Back end: output register that drains the event queue onto the stream.
// Depends on kprd_pkg for the event type.
module kprd_back import kprd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  evt_t       data_i,
  output logic       pop_o,
  output logic       valid_o,
  input  logic       ready_i,
  output evt_t       evt_o
);

  logic valid_q;
  evt_t evt_q;

  // load a new word when the register is empty or being taken
  assign pop_o   = !empty_i && (!valid_q || ready_i);
  assign valid_o = valid_q;
  assign evt_o   = evt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || ready_i) begin
      valid_q <= !empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      evt_q <= data_i;
    end
  end

endmodule

/* rtl/core/keypad_release_detector_with_fn_layer_unit.sv */
// A sample is accepted in idle, walked one key per cycle and then flushed; events leave
// through a 4-entry queue and output register. No new sample is accepted until the
// walk and flush are done; the walk pauses only while the event queue is full.
// Reset (rst_ni low, async): key levels all high, event times zero, fn key 0,
// debounce 50 ms, queue and output empty.
module keypad_release_detector_with_fn_layer_unit import kprd_pkg::*; #(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // key_levels[15:0], now_ms[47:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // key_index[3:0], zero[7:4]
  output logic        m_axis_tuser,   // fn_layer[0]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]  fn_key_q;
  logic [15:0] debounce_q;
  logic        cfg_we;

  logic push;
  evt_t push_evt;
  logic full;
  logic pop;
  logic empty;
  evt_t pop_evt;
  evt_t out_evt;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fn_key_q   <= FN_KEY_RESET;
      debounce_q <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_FN_KEY:   fn_key_q   <= pwdata[3:0];
        REG_DEBOUNCE: debounce_q <= pwdata[15:0];
        default:      fn_key_q   <= fn_key_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FN_KEY:   prdata = {28'd0, fn_key_q};
      REG_DEBOUNCE: prdata = {16'd0, debounce_q};
      default:      prdata = '0;
    endcase
  end

  kprd_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .levels_i   (s_axis_tdata[15:0]),
    .now_i      (s_axis_tdata[47:16]),
    .fn_key_i   (fn_key_q),
    .debounce_i (debounce_q),
    .push_o     (push),
    .evt_o      (push_evt),
    .full_i     (full)
  );

  kprd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_evt),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_evt)
  );

  kprd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .data_i  (pop_evt),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .evt_o   (out_evt)
  );

  assign m_axis_tdata = {4'd0, out_evt.key_index};
  assign m_axis_tuser = out_evt.fn_layer;
  assign m_axis_tlast = out_evt.last;

endmodule
